// ===== hw/rtl/fir_pkg.sv =====
// fir_pkg: shared sizes, command codes and control structs for the FIR filter.
// No dependencies. Used by fir_tap_cell, fir_mac and fir_filter_stream.
`timescale 1ns / 1ps

package fir_pkg;

  localparam int MAX_TAPS   = 128;
  localparam int DATA_WIDTH = 16;
  localparam int ACC_WIDTH  = 40;
  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int CFG_WIDTH  = 8;
  localparam int IDX_WIDTH  = $clog2(MAX_TAPS);
  localparam int CMD_WIDTH  = 2;
  localparam int Q_WIDTH    = ACC_WIDTH - DATA_WIDTH + 2;

  localparam logic [CFG_WIDTH-1:0] TAP_COUNT_RESET = CFG_WIDTH'(101);
  localparam logic [ACC_WIDTH:0]   ROUND_BIAS      = (ACC_WIDTH + 1)'(1) << (DATA_WIDTH - 2);

  typedef logic signed [DATA_WIDTH-1:0] sample_t;
  typedef logic [CMD_WIDTH-1:0] cmd_t;

  localparam cmd_t CMD_FILTER = 2'd0;
  localparam cmd_t CMD_LOAD   = 2'd1;
  localparam cmd_t CMD_CLEAR  = 2'd2;

  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic en;
  } mac_ctrl_t;

  typedef struct packed {
    sample_t value;
    logic    clip;
  } mac_res_t;

endpackage

// ===== hw/rtl/fir_filter_stream.sv =====
// fir_filter_stream: direct-form FIR over a ring of tap cells and one shared MAC.
// Depends on fir_pkg, fir_tap_cell and fir_mac.
//
//   port group   dir  handshake             payload
//   in_*         in   in_valid / in_stall   command, sample_in, tap_index, tap_value
//   out_*        out  out_valid / out_stall filtered_sample, clipped
//   cfg_*        in   cfg_wr_en             tap_count (8 bits)
//
// A filter beat rotates the ring of tap cells once past the single MAC, then
// accumulates the last product in ST_DRAIN and rounds/saturates in ST_FINISH.
// Load and clear beats give no result.
// Synchronous active-low reset zeroes history and coefficients, tap_count = 101.
// Input is stalled while a filter beat is in flight; a held result waits in the
// output register, and the next beat may be accepted meanwhile.
`timescale 1ns / 1ps

module fir_filter_stream (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fir_pkg::cmd_t                     in_command,
  input  fir_pkg::sample_t                  in_sample_in,
  input  logic [fir_pkg::IDX_WIDTH-1:0]     in_tap_index,
  input  fir_pkg::sample_t                  in_tap_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fir_pkg::sample_t                  out_filtered_sample,
  output logic                              out_clipped,
  input  logic                              cfg_wr_en,
  input  logic [fir_pkg::CFG_WIDTH-1:0]     cfg_wr_data
);
  import fir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROT,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                 state_r;
  logic [IDX_WIDTH-1:0]   cnt_r;
  logic [CFG_WIDTH-1:0]   tap_count_r;
  logic [CFG_WIDTH-1:0]   taps_eff;
  logic                   out_valid_r;
  sample_t                out_sample_r;
  logic                   out_clip_r;
  logic                   in_acc;
  logic                   out_load;
  cell_ctrl_t             cell_ctrl;
  mac_ctrl_t              mac_ctrl;
  mac_res_t               mac_res;
  sample_t                x_q [MAX_TAPS];
  sample_t                w_q [MAX_TAPS];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);

  always_comb begin
    priority if (tap_count_r == '0) begin
      taps_eff = CFG_WIDTH'(1);
    end else if (tap_count_r > CFG_WIDTH'(MAX_TAPS)) begin
      taps_eff = CFG_WIDTH'(MAX_TAPS);
    end else begin
      taps_eff = tap_count_r;
    end
  end

  always_comb begin
    cell_ctrl.clear  = in_acc && (in_command == CMD_CLEAR);
    cell_ctrl.shift  = in_acc && (in_command == CMD_FILTER);
    cell_ctrl.rotate = (state_r == ST_ROT);
    mac_ctrl.en      = (state_r == ST_ROT) && (CFG_WIDTH'(cnt_r) < taps_eff);
    mac_ctrl.start   = (state_r == ST_ROT) && (cnt_r == '0);
  end

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    localparam int NEXT = (j + 1) % MAX_TAPS;
    sample_t shift_x;
    logic    load_en;

    if (j == 0) begin : g_head
      assign shift_x = in_sample_in;
    end else begin : g_body
      assign shift_x = x_q[j-1];
    end

    assign load_en = in_acc && (in_command == CMD_LOAD) && (in_tap_index == IDX_WIDTH'(j));

    fir_tap_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cell_ctrl),
      .shift_x (shift_x),
      .rot_x   (x_q[NEXT]),
      .rot_w   (w_q[NEXT]),
      .load_en (load_en),
      .load_w  (in_tap_value),
      .x_q     (x_q[j]),
      .w_q     (w_q[j])
    );
  end

  fir_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .x     (x_q[0]),
    .w     (w_q[0]),
    .res   (mac_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      tap_count_r <= TAP_COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tap_count_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && (in_command == CMD_FILTER)) begin
            state_r <= ST_ROT;
            cnt_r   <= '0;
          end
        end
        ST_ROT: begin
          cnt_r <= cnt_r + IDX_WIDTH'(1);
          if (cnt_r == IDX_WIDTH'(MAX_TAPS - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            out_sample_r <= mac_res.value;
            out_clip_r   <= mac_res.clip;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_clipped         = out_clip_r;

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside finish");

  a_rot_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROT) && (cnt_r == IDX_WIDTH'(MAX_TAPS - 1)) |=> (state_r == ST_DRAIN))
    else $error("rotation did not end after a full turn");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROT) |-> (cnt_r == '0))
    else $error("ring not back in place outside rotation");

  a_no_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mac_ctrl.en && !mac_ctrl.start)
    else $error("mac active while idle");

endmodule

// ===== hw/rtl/fir_tap_cell.sv =====
// fir_tap_cell: one tap of the ring, holds a history sample and a coefficient.
// Depends on fir_pkg.
`timescale 1ns / 1ps

module fir_tap_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  fir_pkg::cell_ctrl_t ctrl,
  input  fir_pkg::sample_t    shift_x,
  input  fir_pkg::sample_t    rot_x,
  input  fir_pkg::sample_t    rot_w,
  input  logic                load_en,
  input  fir_pkg::sample_t    load_w,
  output fir_pkg::sample_t    x_q,
  output fir_pkg::sample_t    w_q
);
  import fir_pkg::*;

  sample_t x_r, x_nxt;
  sample_t w_r, w_nxt;

  always_comb begin
    priority if (ctrl.clear) begin
      x_nxt = '0;
    end else if (ctrl.shift) begin
      x_nxt = shift_x;
    end else if (ctrl.rotate) begin
      x_nxt = rot_x;
    end else begin
      x_nxt = x_r;
    end
  end

  always_comb begin
    priority if (load_en) begin
      w_nxt = load_w;
    end else if (ctrl.rotate) begin
      w_nxt = rot_w;
    end else begin
      w_nxt = w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      w_r <= '0;
    end else begin
      x_r <= x_nxt;
      w_r <= w_nxt;
    end
  end

  assign x_q = x_r;
  assign w_q = w_r;

endmodule

// ===== hw/rtl/fir_mac.sv =====
// fir_mac: registered multiply, wide accumulate, round half up and saturate.
// Depends on fir_pkg.
`timescale 1ns / 1ps

module fir_mac (
  input  logic               clk,
  input  logic               rst_n,
  input  fir_pkg::mac_ctrl_t ctrl,
  input  fir_pkg::sample_t   x,
  input  fir_pkg::sample_t   w,
  output fir_pkg::mac_res_t  res
);
  import fir_pkg::*;

  localparam logic signed [Q_WIDTH-1:0] Q_HI = Q_WIDTH'((2 ** (DATA_WIDTH - 1)) - 1);
  localparam logic signed [Q_WIDTH-1:0] Q_LO = -Q_HI - Q_WIDTH'(1);

  logic signed [PROD_WIDTH-1:0] prod_r;
  logic                         pvld_r;
  logic                         clr_r;
  logic signed [ACC_WIDTH-1:0]  acc_r, acc_nxt;
  logic signed [ACC_WIDTH-1:0]  addend;
  logic [ACC_WIDTH:0]           rnd;
  logic signed [Q_WIDTH-1:0]    q;

  always_comb begin
    addend  = pvld_r ? {{(ACC_WIDTH - PROD_WIDTH){prod_r[PROD_WIDTH-1]}}, prod_r} : '0;
    acc_nxt = (clr_r ? '0 : acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    prod_r <= x * w;
    if (!rst_n) begin
      pvld_r <= 1'b0;
      clr_r  <= 1'b0;
      acc_r  <= '0;
    end else begin
      pvld_r <= ctrl.en;
      clr_r  <= ctrl.start;
      acc_r  <= acc_nxt;
    end
  end

  assign rnd = {acc_r[ACC_WIDTH-1], acc_r} + ROUND_BIAS;
  assign q   = $signed(rnd[ACC_WIDTH:DATA_WIDTH-1]);

  always_comb begin
    priority if (q > Q_HI) begin
      res.value = sample_t'(Q_HI);
      res.clip  = 1'b1;
    end else if (q < Q_LO) begin
      res.value = sample_t'(Q_LO);
      res.clip  = 1'b1;
    end else begin
      res.value = sample_t'(q);
      res.clip  = 1'b0;
    end
  end

endmodule
